FILE: rtl/core/boqt_pkg.sv
`default_nettype none

package boqt_pkg;

  // Default sizes of the table and of the coordinates.
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;

  // Box sizes are always 15-bit unsigned.
  localparam int SIZE_BITS = 15;
  localparam int ACT_W     = 3;
  localparam int STATUS_W  = 2;

  // Entries whose left edge equals this value are never reported by a query.
  localparam int SKIP_LEFT = -1234;

  typedef logic [ACT_W-1:0]    action_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Action codes.
  localparam action_t ACT_INSERT = 3'd0;
  localparam action_t ACT_REMOVE = 3'd1;
  localparam action_t ACT_BOXQ   = 3'd2;
  localparam action_t ACT_EXCLQ  = 3'd3;
  localparam action_t ACT_POINTQ = 3'd4;
  localparam action_t ACT_CLEAR  = 3'd5;

  // Status codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NO_ENTRY = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/box_overlap_query_table_unit.sv
`default_nettype none

// Table of up to TABLE_DEPTH axis-aligned boxes, each in a numbered slot and ranked by age
// (rank 0 is the newest). One transaction inserts a box into the lowest free slot, removes
// a slot, clears the table, or queries for the newest entry that overlaps a box (strict
// edges), overlaps a box but not the box at the current position, or holds a point
// strictly inside; entries whose left edge is -1234 are never reported. Every insert into a
// table with a free slot, remove of a used slot and query walks all TABLE_DEPTH slots
// through one registered-read port of the box and rank memories, one slot per cycle, with
// two overlap comparators; a remove first reads the slot's rank. Drain, commit and reply
// states follow the sweep; clear, an insert into a full table or a remove of a free slot go
// straight to reply, which waits until the output register is free. in_ready is high only
// while no transaction is in progress. No clearing pass is needed after reset.
module box_overlap_query_table_unit #(
  parameter int  TABLE_DEPTH = boqt_pkg::TABLE_DEPTH_DEF,
  parameter int  COORD_BITS  = boqt_pkg::COORD_BITS_DEF,
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  boqt_pkg::action_t                     in_action,
  input  logic signed [COORD_BITS-1:0]          in_pos_x,
  input  logic signed [COORD_BITS-1:0]          in_pos_y,
  input  logic [boqt_pkg::SIZE_BITS-1:0]        in_size_w,
  input  logic [boqt_pkg::SIZE_BITS-1:0]        in_size_h,
  input  logic signed [COORD_BITS-1:0]          in_cur_x,
  input  logic signed [COORD_BITS-1:0]          in_cur_y,
  input  logic [SLOT_W-1:0]                     in_slot_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output boqt_pkg::status_t                     out_status,
  output logic                                  out_hit,
  output logic [SLOT_W-1:0]                     out_slot_out
);
  import boqt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS + 1) + 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(TABLE_DEPTH);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RANK   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_REPLY  = 3'd5;

  // Box and rank memories.
  logic signed [COORD_BITS-1:0] left_mem [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] top_mem  [TABLE_DEPTH];
  logic [SIZE_BITS-1:0]         wid_mem  [TABLE_DEPTH];
  logic [SIZE_BITS-1:0]         hgt_mem  [TABLE_DEPTH];
  logic [SLOT_W-1:0]            rank_mem [TABLE_DEPTH];

  logic [2:0]                   state_r, state_nxt;
  action_t                      action_r;
  logic signed [COORD_BITS-1:0] qx_r, qy_r, cx_r, cy_r;
  logic [SIZE_BITS-1:0]         qw_r, qh_r;
  logic [SLOT_W-1:0]            rem_rank_r;
  logic [SLOT_W-1:0]            idx_r;
  logic                         pipe_vld_r;
  logic [SLOT_W-1:0]            pipe_idx_r;
  logic                         pipe_used_r;
  logic signed [COORD_BITS-1:0] left_q_r, top_q_r;
  logic [SIZE_BITS-1:0]         wid_q_r, hgt_q_r;
  logic [SLOT_W-1:0]            rank_q_r;
  logic                         found_r;
  logic [SLOT_W-1:0]            best_rank_r, best_slot_r;
  logic                         free_found_r;
  logic [SLOT_W-1:0]            free_slot_r;
  logic [TABLE_DEPTH-1:0]       used_r;
  logic [CNT_W-1:0]             count_r;
  status_t                      res_status_r;
  logic                         res_hit_r;
  logic [SLOT_W-1:0]            res_slot_r;
  logic                         out_valid_r;
  status_t                      out_status_r;
  logic                         out_hit_r;
  logic [SLOT_W-1:0]            out_slot_r;

  logic                         accept;
  logic                         reply_load;
  logic [SLOT_W-1:0]            rd_addr;
  logic                         box_we;
  logic                         rank_we;
  logic [SLOT_W-1:0]            rank_wa;
  logic [SLOT_W-1:0]            rank_wd;
  logic                         is_query;
  logic                         ent_ok;
  logic                         not_skip;
  logic                         meet_pos;
  logic                         meet_cur;
  logic                         match;
  logic                         better;
  logic signed [EXT_W-1:0]      ex_l, ex_t, ex_bw, ex_bh;
  logic signed [EXT_W-1:0]      ex_qx, ex_qy, ex_cx, ex_cy, ex_qw, ex_qh;

  // Strict overlap of box (x, y, w, h) with stored box (l, t, bw, bh).
  function automatic logic boxes_meet(
    input logic signed [EXT_W-1:0] x,
    input logic signed [EXT_W-1:0] y,
    input logic signed [EXT_W-1:0] w,
    input logic signed [EXT_W-1:0] h,
    input logic signed [EXT_W-1:0] l,
    input logic signed [EXT_W-1:0] t,
    input logic signed [EXT_W-1:0] bw,
    input logic signed [EXT_W-1:0] bh
  );
    return (x + w > l) && (x < l + bw) && (y + h > t) && (y < t + bh);
  endfunction

  assign accept     = in_valid && (state_r == S_IDLE);
  assign in_ready   = (state_r == S_IDLE);
  assign reply_load = (state_r == S_REPLY) && (!out_valid_r || out_ready);

  // The read port serves the rank lookup of a remove at accept time, and the sweep after.
  assign rd_addr = (state_r == S_IDLE) ? in_slot_in : idx_r;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (box_we) begin
      left_mem[free_slot_r] <= qx_r;
      top_mem[free_slot_r]  <= qy_r;
      wid_mem[free_slot_r]  <= qw_r;
      hgt_mem[free_slot_r]  <= qh_r;
    end
    left_q_r <= left_mem[rd_addr];
    top_q_r  <= top_mem[rd_addr];
    wid_q_r  <= wid_mem[rd_addr];
    hgt_q_r  <= hgt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    rank_q_r <= rank_mem[rd_addr];
  end

  // Overlap comparators on the entry read in the previous cycle.
  assign ex_l  = EXT_W'(left_q_r);
  assign ex_t  = EXT_W'(top_q_r);
  assign ex_bw = EXT_W'(wid_q_r);
  assign ex_bh = EXT_W'(hgt_q_r);
  assign ex_qx = EXT_W'(qx_r);
  assign ex_qy = EXT_W'(qy_r);
  assign ex_cx = EXT_W'(cx_r);
  assign ex_cy = EXT_W'(cy_r);
  assign ex_qw = EXT_W'(qw_r);
  assign ex_qh = EXT_W'(qh_r);

  assign meet_pos = boxes_meet(ex_qx, ex_qy, ex_qw, ex_qh, ex_l, ex_t, ex_bw, ex_bh);
  assign meet_cur = boxes_meet(ex_cx, ex_cy, ex_qw, ex_qh, ex_l, ex_t, ex_bw, ex_bh);

  assign is_query = (action_r == ACT_BOXQ) || (action_r == ACT_EXCLQ) ||
                    (action_r == ACT_POINTQ);
  assign ent_ok   = pipe_vld_r && pipe_used_r;
  assign not_skip = (int'(left_q_r) != SKIP_LEFT);
  assign match    = (action_r == ACT_EXCLQ) ? (meet_pos && !meet_cur) : meet_pos;
  assign better   = !found_r || (rank_q_r < best_rank_r);

  // Memory write control: ageing or remove renumbering in the sweep, new entry at commit.
  always_comb begin
    box_we  = 1'b0;
    rank_we = 1'b0;
    rank_wa = pipe_idx_r;
    rank_wd = rank_q_r + SLOT_W'(1);
    if ((state_r == S_COMMIT) && (action_r == ACT_INSERT)) begin
      box_we  = 1'b1;
      rank_we = 1'b1;
      rank_wa = free_slot_r;
      rank_wd = '0;
    end else if (ent_ok && (action_r == ACT_INSERT)) begin
      rank_we = 1'b1;
    end else if (ent_ok && (action_r == ACT_REMOVE) && (rank_q_r > rem_rank_r)) begin
      rank_we = 1'b1;
      rank_wd = rank_q_r - SLOT_W'(1);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_action == ACT_INSERT) begin
            state_nxt = (count_r == FULL_CNT) ? S_REPLY : S_SWEEP;
          end else if (in_action == ACT_REMOVE) begin
            if ((int'(in_slot_in) >= TABLE_DEPTH) || !used_r[in_slot_in]) begin
              state_nxt = S_REPLY;
            end else begin
              state_nxt = S_RANK;
            end
          end else if ((in_action == ACT_BOXQ) || (in_action == ACT_EXCLQ) ||
                       (in_action == ACT_POINTQ)) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_REPLY;
          end
        end
      end
      S_RANK:   state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_REPLY;
      S_REPLY: begin
        if (reply_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer and table control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      count_r      <= '0;
      pipe_vld_r   <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pipe_vld_r <= (state_r == S_SWEEP);

      if (accept) begin
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        if (in_action == ACT_CLEAR) begin
          used_r  <= '0;
          count_r <= '0;
        end else if ((in_action == ACT_REMOVE) && (int'(in_slot_in) < TABLE_DEPTH) &&
                     used_r[in_slot_in]) begin
          used_r[in_slot_in] <= 1'b0;
          count_r            <= count_r - CNT_W'(1);
        end
      end

      // Sweep stage: free-slot search and newest-match tracking.
      if (pipe_vld_r && !pipe_used_r && !free_found_r && (action_r == ACT_INSERT)) begin
        free_found_r <= 1'b1;
      end
      if (ent_ok && is_query && not_skip && match && better) begin
        found_r <= 1'b1;
      end

      if ((state_r == S_COMMIT) && (action_r == ACT_INSERT)) begin
        used_r[free_slot_r] <= 1'b1;
        count_r             <= count_r + CNT_W'(1);
      end
    end
  end

  // Operand capture, sweep index and per-entry results.
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      qx_r     <= in_pos_x;
      qy_r     <= in_pos_y;
      cx_r     <= in_cur_x;
      cy_r     <= in_cur_y;
      // A point query is a box query with zero size.
      qw_r     <= (in_action == ACT_POINTQ) ? '0 : in_size_w;
      qh_r     <= (in_action == ACT_POINTQ) ? '0 : in_size_h;
      idx_r    <= '0;
    end else if (state_r == S_SWEEP) begin
      idx_r <= idx_r + SLOT_W'(1);
    end
    if (state_r == S_RANK) begin
      rem_rank_r <= rank_q_r;
    end
    pipe_idx_r  <= idx_r;
    pipe_used_r <= used_r[idx_r];
    if (pipe_vld_r && !pipe_used_r && !free_found_r) begin
      free_slot_r <= pipe_idx_r;
    end
    if (ent_ok && is_query && not_skip && match && better) begin
      best_rank_r <= rank_q_r;
      best_slot_r <= pipe_idx_r;
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit_r  <= 1'b0;
      res_slot_r <= '0;
      if ((in_action == ACT_INSERT) && (count_r == FULL_CNT)) begin
        res_status_r <= ST_FULL;
      end else if ((in_action == ACT_REMOVE) &&
                   ((int'(in_slot_in) >= TABLE_DEPTH) || !used_r[in_slot_in])) begin
        res_status_r <= ST_NO_ENTRY;
      end else begin
        res_status_r <= ST_OK;
      end
    end else if (state_r == S_COMMIT) begin
      if (action_r == ACT_INSERT) begin
        res_slot_r <= free_slot_r;
      end else if (is_query && found_r) begin
        res_hit_r  <= 1'b1;
        res_slot_r <= best_slot_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (reply_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_load) begin
      out_status_r <= res_status_r;
      out_hit_r    <= res_hit_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_hit      = out_hit_r;
  assign out_slot_out = out_slot_r;

endmodule

`default_nettype wire

FILE: rtl/core/boqt_checker.sv
`default_nettype none

module boqt_checker #(
  parameter int SLOT_W = 6
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input boqt_pkg::status_t  out_status,
  input logic               out_hit,
  input logic [SLOT_W-1:0]  out_slot_out
);
  import boqt_pkg::*;

  // A stalled result transaction holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_hit) &&
                                $stable(out_slot_out))
    else $error("result changed while stalled");

  // Once a transaction is taken, the block is still busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a transaction");

  // An error status carries no hit and slot zero.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_hit && (out_slot_out == '0))
    else $error("error result with hit or slot set");

  // A hit only comes with status ok.
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_status == ST_OK))
    else $error("hit reported with error status");

endmodule

bind box_overlap_query_table_unit boqt_checker #(.SLOT_W(SLOT_W)) u_boqt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_hit      (out_hit),
  .out_slot_out (out_slot_out)
);

`default_nettype wire
